// File: hw/rtl/bls_pkg.sv
`default_nettype none

package bls_pkg;

    // Request opcodes; the unused code acts as status
    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_REPLACE = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_MEMBER  = 3'd4,
        OP_PEEK    = 3'd5,
        OP_STATUS  = 3'd6
    } op_t;

    // Error codes reported with every result
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] value;
        logic [7:0] pop_count;
    } req_t;

    typedef struct packed {
        logic [7:0] top_value;
        logic [6:0] entry_count;
        logic       is_full;
        logic       is_empty;
        logic       found;
        logic [1:0] error_code;
    } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/bounded_lifo_stack.sv
// Bounded byte stack with a request and a result channel, both valid/ready.
// Each accepted request (s_data) yields exactly one result (m_data) carrying
// the top byte, entry count, full/empty flags, member hit and error code.
// Entries live in a single-port-write, registered-read memory of STACK_DEPTH
// bytes; the top byte is also kept in a register.
// Request handling, with m_ready held high:
//   push, replace, clear, peek, status: result in the cycle after acceptance,
//     next request taken in the following cycle (one per cycle).
//   pop: when entries remain, the result waits for an extra memory read of the
//     new top; it is loaded directly when the pop empties the stack.
//   member query: one memory read per stored entry before the result.
// One request is in flight at a time; s_ready is low during pop reads and
// member scans. The result sits in an output register; when the receiver
// stalls, that register holds and s_ready drops until the result is taken.
// Reset (aresetn low, synchronous) empties the stack and drops any result;
// memory contents are not cleared since only entries below the count are read.
`default_nettype none

module bounded_lifo_stack
    import bls_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  wire  m_ready,
    output rsp_t m_data
);

    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = (FW > 8) ? FW : 8;
    localparam int EW = (FW > 7) ? FW : 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_SCAN
    } state_t;

    state_t         state_reg, state_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [7:0]     top_reg, top_next;
    logic [7:0]     val_reg, val_next;
    logic [AW-1:0]  scan_reg, scan_next;
    logic           hit_reg, hit_next;
    logic           m_valid_reg;
    rsp_t           m_data_reg;

    // Entry memory
    logic [7:0]     mem [STACK_DEPTH];
    logic [7:0]     rd_data_reg;
    logic           wr_en, rd_en;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic [7:0]     wr_data;

    logic           accept;
    logic           out_load;
    logic           res_found;
    err_t           res_err;
    logic           scan_hit;
    logic [7:0]     pop_cnt;
    logic [CW-1:0]  pop_cnt_w, fill_cw;
    logic [EW-1:0]  fill_wide;
    rsp_t           res;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Effective pop count; zero means one
    assign pop_cnt   = (s_data.pop_count == 8'd0) ? 8'd1 : s_data.pop_count;
    assign pop_cnt_w = CW'(pop_cnt);
    assign fill_cw   = CW'(fill_reg);
    assign scan_hit  = hit_reg | (rd_data_reg == val_reg);

    // Next-state and memory access decode
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        top_next   = top_reg;
        val_next   = val_reg;
        scan_next  = scan_reg;
        hit_next   = hit_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = s_data.value;
        rd_en      = 1'b0;
        rd_addr    = '0;
        out_load   = 1'b0;
        res_found  = 1'b0;
        res_err    = ERR_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op_t'(s_data.opcode))
                        OP_PUSH: begin
                            out_load = 1'b1;
                            if (fill_reg == FW'(STACK_DEPTH)) begin
                                res_err = ERR_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = AW'(fill_reg);
                                fill_next = fill_reg + 1'b1;
                                top_next  = s_data.value;
                            end
                        end
                        OP_POP: begin
                            if (pop_cnt_w > fill_cw) begin
                                fill_next = '0;
                                res_err   = ERR_EMPTY;
                                out_load  = 1'b1;
                            end else begin
                                fill_next = FW'(fill_cw - pop_cnt_w);
                                if (fill_next == '0) begin
                                    out_load = 1'b1;
                                end else begin
                                    // fetch the new top before answering
                                    rd_en      = 1'b1;
                                    rd_addr    = AW'(fill_next - 1'b1);
                                    state_next = ST_POP_RD;
                                end
                            end
                        end
                        OP_REPLACE: begin
                            out_load = 1'b1;
                            wr_en    = 1'b1;
                            top_next = s_data.value;
                            if (fill_reg == '0) begin
                                res_err   = ERR_EMPTY;
                                wr_addr   = '0;
                                fill_next = FW'(1);
                            end else begin
                                wr_addr = AW'(fill_reg - 1'b1);
                            end
                        end
                        OP_CLEAR: begin
                            fill_next = '0;
                            out_load  = 1'b1;
                        end
                        OP_MEMBER: begin
                            if (fill_reg == '0) begin
                                out_load = 1'b1;
                            end else begin
                                // walk entries from the bottom
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                scan_next  = '0;
                                hit_next   = 1'b0;
                                val_next   = s_data.value;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_PEEK: begin
                            out_load = 1'b1;
                            if (fill_reg == '0) begin
                                res_err = ERR_EMPTY;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_RD: begin
                top_next   = rd_data_reg;
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_reg == AW'(fill_reg - 1'b1)) begin
                    res_found  = scan_hit;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg + 1'b1;
                    scan_next = scan_reg + 1'b1;
                    hit_next  = scan_hit;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result assembly from the post-operation state
    assign fill_wide = EW'(fill_next);

    always_comb begin
        res.top_value   = (fill_next == '0) ? 8'd0 : top_next;
        res.entry_count = fill_wide[6:0];
        res.is_full     = (fill_next == FW'(STACK_DEPTH));
        res.is_empty    = (fill_next == '0);
        res.found       = res_found;
        res.error_code  = res_err;
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // State and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        top_reg  <= top_next;
        val_reg  <= val_next;
        scan_reg <= scan_next;
        hit_reg  <= hit_next;
        if (out_load) begin
            m_data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bls_checker.sv
`default_nettype none

module bls_checker
    import bls_pkg::*;
(
    input wire  aclk,
    input wire  aresetn,
    input wire  s_valid,
    input wire  s_ready,
    input wire  m_valid,
    input wire  m_ready,
    input rsp_t m_data
);

    logic [1:0] pending_reg;
    logic       req_acc, rsp_acc;

    assign req_acc = s_valid && s_ready;
    assign rsp_acc = m_valid && m_ready;

    // Requests accepted but not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + {1'b0, req_acc} - {1'b0, rsp_acc};
        end
    end

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result without an outstanding request
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result without request");

    // One request in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        req_acc |-> pending_reg == 2'd0 || rsp_acc)
        else $error("request taken while another is outstanding");

    // A member hit never comes with an error
    a_found_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.error_code == ERR_NONE)
        else $error("found flagged with error");

    // A dropped push only happens on a full stack
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code == ERR_FULL |-> m_data.is_full && !m_data.is_empty)
        else $error("overflow reported on a stack that is not full");

endmodule

bind bounded_lifo_stack bls_checker u_bls_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
